// ----- hw/rtl/xccr_pkg.sv -----
package xccr_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned ID_W      = 24;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = ID_W;
	localparam int unsigned OUTCOME_W = 3;
	localparam int unsigned POS_W     = 2;
	localparam int unsigned REPLY_LEN = 7;
	localparam int unsigned WIDX_W    = $clog2(REPLY_LEN);

	localparam logic [POS_W-1:0]  POS_MAX       = '1;
	localparam logic [POS_W-1:0]  MIN_LEN       = POS_W'(3);
	localparam logic [BYTE_W-1:0] REPLY_OK_BYTE = 8'h01;

	typedef enum logic [OUTCOME_W-1:0] {
		OUTCOME_OK        = 3'd0,
		OUTCOME_SHORT     = 3'd1,
		OUTCOME_BAD_CHECK = 3'd2,
		OUTCOME_BAD_HDR   = 3'd3,
		OUTCOME_BAD_CMD   = 3'd4
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEVICE_ID   = 3'd0,
		REG_RX_HEADER   = 3'd1,
		REG_TX_HEADER   = 3'd2,
		REG_UNLOCK_CODE = 3'd3,
		REG_LOCK_CODE   = 3'd4
	} reg_idx_t;

	// position of each word inside a reply
	typedef enum logic [WIDX_W-1:0] {
		W_HEADER = 3'd0,
		W_CMD    = 3'd1,
		W_OK     = 3'd2,
		W_ID_HI  = 3'd3,
		W_ID_MID = 3'd4,
		W_ID_LO  = 3'd5,
		W_CHECK  = 3'd6
	} word_idx_t;

endpackage

// ----- hw/rtl/xccr_in_if.sv -----
interface xccr_in_if;
	logic                         valid;
	logic                         ready;
	logic [xccr_pkg::BYTE_W-1:0]  frame_byte;
	logic                         frame_end;

	modport source (output valid, output frame_byte, output frame_end, input ready);
	modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ----- hw/rtl/xccr_out_if.sv -----
interface xccr_out_if;
	logic                            valid;
	logic                            ready;
	logic [xccr_pkg::BYTE_W-1:0]     reply_byte;
	logic [xccr_pkg::OUTCOME_W-1:0]  outcome;
	logic                            run_end;

	modport source (output valid, output reply_byte, output outcome, output run_end,
		input ready);
	modport sink   (input valid, input reply_byte, input outcome, input run_end,
		output ready);
endinterface

// ----- hw/rtl/xor_checked_command_responder_core.sv -----
// Channel   Dir  Payload                              Word
// in_ch     in   frame_byte[7:0], frame_end           one command frame byte
// out_ch    out  reply_byte[7:0], outcome[2:0], run_end  one reply or error word
// cfg_*     in   cfg_we, cfg_index[2:0], cfg_wdata[23:0]  register write
//
// Frame bytes are taken one per cycle while in_ch.ready is high; the frame
// state (position, XOR, header match, command) updates at the accepting edge.
// A frame-end byte loads a reply job; its first word shows in the next cycle.
// An ok reply is seven words on out_ch, an error reply one word; the word
// counter widx_q steps through them. Non-end bytes are taken even while a
// job drains; in_ch.ready drops for a frame-end byte while a job is loaded,
// unless its final word is being accepted.
// Reset zeroes frame state, job control and config registers; not the reply payload.
module xor_checked_command_responder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xccr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [xccr_pkg::CFG_W-1:0]       cfg_wdata,
	xccr_in_if.sink                          in_ch,
	xccr_out_if.source                       out_ch
);

	// configuration registers
	logic [xccr_pkg::ID_W-1:0]   device_id_q;
	logic [xccr_pkg::BYTE_W-1:0] rx_header_q;
	logic [xccr_pkg::BYTE_W-1:0] tx_header_q;
	logic [xccr_pkg::BYTE_W-1:0] unlock_code_q;
	logic [xccr_pkg::BYTE_W-1:0] lock_code_q;

	// frame state
	logic [xccr_pkg::POS_W-1:0]  pos_q;
	logic [xccr_pkg::BYTE_W-1:0] xor_q;
	logic                        hdr_ok_q;
	logic [xccr_pkg::BYTE_W-1:0] cmd_q;

	// reply job
	logic                        busy_q;
	xccr_pkg::outcome_t          outcome_q;
	logic [xccr_pkg::WIDX_W-1:0] widx_q;
	logic [xccr_pkg::BYTE_W-1:0] job_hdr_q;
	logic [xccr_pkg::BYTE_W-1:0] job_cmd_q;
	logic [xccr_pkg::ID_W-1:0]   job_id_q;
	logic [xccr_pkg::BYTE_W-1:0] job_chk_q;

	logic                        in_fire, out_fire, last_word;
	logic [xccr_pkg::POS_W-1:0]  pos_n;
	logic [xccr_pkg::BYTE_W-1:0] xor_n;
	logic                        hdr_ok_n;
	logic [xccr_pkg::BYTE_W-1:0] cmd_n;
	xccr_pkg::outcome_t          outcome_n;
	logic [xccr_pkg::BYTE_W-1:0] word;

	assign out_fire  = out_ch.valid & out_ch.ready;
	assign last_word = (outcome_q != xccr_pkg::OUTCOME_OK) ||
		(widx_q == xccr_pkg::W_CHECK);
	// a frame-end byte needs the job slot; free it on the final word
	assign in_ch.ready = !busy_q || !in_ch.frame_end || (out_fire && last_word);
	assign in_fire     = in_ch.valid & in_ch.ready;

	// next frame state, as seen after this byte
	always_comb begin
		pos_n    = (pos_q == xccr_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;
		xor_n    = xor_q ^ in_ch.frame_byte;
		hdr_ok_n = (pos_q == '0) ? (in_ch.frame_byte == rx_header_q) : hdr_ok_q;
		cmd_n    = (pos_q == xccr_pkg::POS_W'(1)) ? in_ch.frame_byte : cmd_q;

		if (pos_n < xccr_pkg::MIN_LEN)
			outcome_n = xccr_pkg::OUTCOME_SHORT;
		else if (xor_n != '0)
			outcome_n = xccr_pkg::OUTCOME_BAD_CHECK;
		else if (!hdr_ok_n)
			outcome_n = xccr_pkg::OUTCOME_BAD_HDR;
		else if (cmd_n != unlock_code_q && cmd_n != lock_code_q)
			outcome_n = xccr_pkg::OUTCOME_BAD_CMD;
		else
			outcome_n = xccr_pkg::OUTCOME_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q   <= '0;
			rx_header_q   <= '0;
			tx_header_q   <= '0;
			unlock_code_q <= '0;
			lock_code_q   <= '0;
		end else if (cfg_we) begin
			case (xccr_pkg::reg_idx_t'(cfg_index))
				xccr_pkg::REG_DEVICE_ID:   device_id_q   <= cfg_wdata;
				xccr_pkg::REG_RX_HEADER:   rx_header_q   <= cfg_wdata[xccr_pkg::BYTE_W-1:0];
				xccr_pkg::REG_TX_HEADER:   tx_header_q   <= cfg_wdata[xccr_pkg::BYTE_W-1:0];
				xccr_pkg::REG_UNLOCK_CODE: unlock_code_q <= cfg_wdata[xccr_pkg::BYTE_W-1:0];
				xccr_pkg::REG_LOCK_CODE:   lock_code_q   <= cfg_wdata[xccr_pkg::BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// frame accumulation; cleared after the check byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			xor_q    <= '0;
			hdr_ok_q <= 1'b0;
			cmd_q    <= '0;
		end else if (in_fire) begin
			if (in_ch.frame_end) begin
				pos_q    <= '0;
				xor_q    <= '0;
				hdr_ok_q <= 1'b0;
				cmd_q    <= '0;
			end else begin
				pos_q    <= pos_n;
				xor_q    <= xor_n;
				hdr_ok_q <= hdr_ok_n;
				cmd_q    <= cmd_n;
			end
		end
	end

	// job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			outcome_q <= xccr_pkg::OUTCOME_OK;
			widx_q    <= '0;
		end else if (in_fire && in_ch.frame_end) begin
			busy_q    <= 1'b1;
			outcome_q <= outcome_n;
			widx_q    <= '0;
		end else if (out_fire) begin
			if (last_word)
				busy_q <= 1'b0;
			else
				widx_q <= widx_q + 1'b1;
		end
	end

	// reply payload, captured with the job
	always_ff @(posedge clk) begin
		if (in_fire && in_ch.frame_end) begin
			job_hdr_q <= tx_header_q;
			job_cmd_q <= cmd_n;
			job_id_q  <= device_id_q;
			job_chk_q <= tx_header_q ^ cmd_n ^ xccr_pkg::REPLY_OK_BYTE ^
				device_id_q[23:16] ^ device_id_q[15:8] ^ device_id_q[7:0];
		end
	end

	always_comb begin
		case (xccr_pkg::word_idx_t'(widx_q))
			xccr_pkg::W_HEADER: word = job_hdr_q;
			xccr_pkg::W_CMD:    word = job_cmd_q;
			xccr_pkg::W_OK:     word = xccr_pkg::REPLY_OK_BYTE;
			xccr_pkg::W_ID_HI:  word = job_id_q[23:16];
			xccr_pkg::W_ID_MID: word = job_id_q[15:8];
			xccr_pkg::W_ID_LO:  word = job_id_q[7:0];
			xccr_pkg::W_CHECK:  word = job_chk_q;
			default:            word = '0;
		endcase
	end

	assign out_ch.valid      = busy_q;
	assign out_ch.reply_byte = (outcome_q == xccr_pkg::OUTCOME_OK) ? word : '0;
	assign out_ch.outcome    = outcome_q;
	assign out_ch.run_end    = last_word;

endmodule
